// ----- hw/rtl/grfa_pkg.sv -----
// ----------------------------------------------------------------------------
// grfa_pkg
// Shared types and codes of the grid rectangle first-fit allocator.
// ----------------------------------------------------------------------------
package grfa_pkg;

   localparam int DEF_MAX_COLUMNS = 16;
   localparam int DEF_MAX_ROWS    = 16;

   localparam int CFG_W      = 5;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int NUM_W      = 8;
   localparam int COUNT_W    = 9;

   localparam logic [0:0] REG_GRID_COLUMNS = 1'b0;
   localparam logic [0:0] REG_GRID_ROWS    = 1'b1;

   localparam logic MODE_PLACE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [1:0] ST_PLACED   = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_OCCUPIED = 2'd3;

   typedef struct packed {
      logic load;
      logic q_step;
      logic q_read;
      logic set_empty;
      logic set_query;
      logic set_nofit;
      logic s_init;
      logic rd_row;
      logic acc_row;
      logic next_top;
      logic p_init;
      logic wr_lo;
      logic wr_hi;
      logic own_init;
      logic own_wr;
      logic p_next_row;
      logic finish;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic q_in;
      logic q_done;
      logic pre_ok;
      logic dy_last;
      logic fit_found;
      logic top_last;
      logic dx_last;
   } sts_type;

endpackage

// ----- hw/rtl/grfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// grfa_ctrl
// Sequencer: query lookup, anchor-row scan, rectangle write, result handoff.
// ----------------------------------------------------------------------------
module grfa_ctrl
   import grfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_QSUB  = 4'd1;
   localparam logic [3:0] S_QWAIT = 4'd2;
   localparam logic [3:0] S_PCHK  = 4'd3;
   localparam logic [3:0] S_SRD   = 4'd4;
   localparam logic [3:0] S_SACC  = 4'd5;
   localparam logic [3:0] S_SFIT  = 4'd6;
   localparam logic [3:0] S_PRD   = 4'd7;
   localparam logic [3:0] S_PWLO  = 4'd8;
   localparam logic [3:0] S_PWHI  = 4'd9;
   localparam logic [3:0] S_POWN  = 4'd10;
   localparam logic [3:0] S_RESP  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_QSUB;
            end
         end
         S_QSUB: begin
            // mode is known only after capture
            if (!sts.is_query) begin
               state_in = S_PCHK;
            end else if (!sts.q_in) begin
               cmd.set_empty = 1'b1;
               state_in      = S_RESP;
            end else if (sts.q_done) begin
               cmd.q_read = 1'b1;
               state_in   = S_QWAIT;
            end else begin
               cmd.q_step = 1'b1;
            end
         end
         S_QWAIT: begin
            cmd.set_query = 1'b1;
            state_in      = S_RESP;
         end
         S_PCHK: begin
            if (!sts.pre_ok) begin
               cmd.set_nofit = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.s_init = 1'b1;
               state_in   = S_SRD;
            end
         end
         S_SRD: begin
            cmd.rd_row = 1'b1;
            state_in   = S_SACC;
         end
         S_SACC: begin
            cmd.acc_row = 1'b1;
            state_in    = sts.dy_last ? S_SFIT : S_SRD;
         end
         S_SFIT: begin
            if (sts.fit_found) begin
               cmd.p_init = 1'b1;
               state_in   = S_PRD;
            end else if (sts.top_last) begin
               cmd.set_nofit = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.next_top = 1'b1;
               state_in     = S_SRD;
            end
         end
         S_PRD: begin
            cmd.rd_row = 1'b1;
            state_in   = S_PWLO;
         end
         S_PWLO: begin
            cmd.wr_lo = 1'b1;
            state_in  = S_PWHI;
         end
         S_PWHI: begin
            cmd.wr_hi    = 1'b1;
            cmd.own_init = 1'b1;
            state_in     = S_POWN;
         end
         S_POWN: begin
            cmd.own_wr = 1'b1;
            if (sts.dx_last) begin
               if (sts.dy_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_RESP;
               end else begin
                  cmd.p_next_row = 1'b1;
                  state_in       = S_PRD;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || cmd.rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_resp_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && !rsp_tready) |=>
      (state_ff == S_RESP && rsp_valid_ff))
      else $error("result overwrote an untaken item");

   a_valid_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("result raised outside handoff state");

endmodule

// ----- hw/rtl/grfa_dp.sv -----
// ----------------------------------------------------------------------------
// grfa_dp
// Datapath: geometry registers, word-packed occupancy memory, owner memory,
// scan counters, fit finder and result registers.
// ----------------------------------------------------------------------------
module grfa_dp
   import grfa_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_wr_en,
   input  logic [0:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wr_data,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int W     = MAX_COLUMNS;
   localparam int NR    = MAX_ROWS;
   localparam int DEPTH = W * NR;
   localparam int CW    = $clog2(W + 1);
   localparam int RW    = $clog2(NR + 1);
   localparam int OW    = (W > 1) ? $clog2(W) : 1;
   localparam int AW    = (NR > 1) ? $clog2(NR) : 1;
   localparam int LW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QW    = (CW > 8) ? CW : 8;
   localparam int SW    = $clog2(2 * W);
   localparam int XW    = (LW + 1 > 8) ? LW + 1 : 8;

   function automatic int clamp_dim(int v, int m);
      if (v < 1) return 1;
      if (v > m) return m;
      return v;
   endfunction

   // geometry
   logic [CFG_W-1:0]   cfg_cols_ff, cfg_rows_ff;
   logic [CW-1:0]      cols;
   logic [RW-1:0]      rows;
   logic [CW+RW-1:0]   cells;
   logic [W-1:0]       colmask, wmask;

   // request
   logic               mode_ff;
   logic [4:0]         w_ff, h_ff;
   logic [7:0]         q_ff;
   logic [QW-1:0]      qoff_ff;
   logic [AW-1:0]      qword_ff;

   // scan / place
   logic [RW-1:0]      sy_ff;
   logic [4:0]         dy_ff, dx_ff;
   logic [AW-1:0]      sw_ff, rw_ff, sw_in, rw_in;
   logic [OW-1:0]      so_ff, ro_ff, so_in, ro_in, px_ff, fit_x;
   logic [SW-1:0]      sum_s, sum_r;
   logic [LW:0]        sbase_ff, rowlin_ff;
   logic [W-1:0]       acc_ff, rowbits, m_row;
   logic [2*W-1:0]     ext;
   logic               fit_found;
   logic [COUNT_W-1:0] count_ff;
   logic [XW-1:0]      anchor_full;
   logic [LW:0]        own_sum;

   // occupancy memory, one word per MAX_COLUMNS cells
   logic [W-1:0]       occ_mem [NR];
   logic               occ_vld_ff [NR];
   logic [W-1:0]       rd_lo_ff, rd_hi_ff, lo_word, hi_word;
   logic               vld_lo_ff, vld_hi_ff;
   logic [AW-1:0]      rd_addr, rd_addr_hi, wr_addr;
   logic [AW:0]        hi_sum;
   logic               hi_ok, rd_en, wr_en;
   logic [W-1:0]       wr_data;

   // owner memory: {anchor flag, item number}
   logic [NUM_W:0]     own_mem [DEPTH];
   logic [NUM_W:0]     own_rd_ff;

   // results
   logic [1:0]         res_status_ff, rsp_status_ff;
   logic [7:0]         res_anchor_ff, rsp_anchor_ff;
   logic [7:0]         res_owner_ff, rsp_owner_ff;
   logic               res_is_anchor_ff, rsp_is_anchor_ff;

   always_comb begin
      cols  = CW'(clamp_dim(int'(cfg_cols_ff), W));
      rows  = RW'(clamp_dim(int'(cfg_rows_ff), NR));
      cells = (CW + RW)'(cols) * (CW + RW)'(rows);
      for (int i = 0; i < W; i++) begin
         colmask[i] = (i < int'(cols));
         wmask[i]   = (i < int'(w_ff));
      end
   end

   // step a (word, offset) position forward by one grid row
   always_comb begin
      sum_s = SW'(so_ff) + SW'(cols);
      if (sum_s >= SW'(W)) begin
         so_in = OW'(sum_s - SW'(W));
         sw_in = sw_ff + 1'b1;
      end else begin
         so_in = OW'(sum_s);
         sw_in = sw_ff;
      end
      sum_r = SW'(ro_ff) + SW'(cols);
      if (sum_r >= SW'(W)) begin
         ro_in = OW'(sum_r - SW'(W));
         rw_in = rw_ff + 1'b1;
      end else begin
         ro_in = OW'(sum_r);
         rw_in = rw_ff;
      end
   end

   // memory addressing
   always_comb begin
      rd_addr    = cmd.q_read ? qword_ff : rw_ff;
      hi_sum     = {1'b0, rd_addr} + 1'b1;
      hi_ok      = (int'(hi_sum) < NR);
      rd_addr_hi = hi_ok ? hi_sum[AW-1:0] : '0;
      rd_en      = cmd.rd_row || cmd.q_read;
      lo_word    = vld_lo_ff ? rd_lo_ff : '0;
      hi_word    = vld_hi_ff ? rd_hi_ff : '0;
      rowbits    = W'({hi_word, lo_word} >> ro_ff) & colmask;
      m_row      = wmask << px_ff;
      ext        = {{W{1'b0}}, m_row} << ro_ff;
      wr_en      = cmd.wr_lo || (cmd.wr_hi && hi_ok);
      wr_addr    = cmd.wr_hi ? rd_addr_hi : rd_addr;
      wr_data    = cmd.wr_hi ? (hi_word | ext[2*W-1:W]) : (lo_word | ext[W-1:0]);
   end

   // first free window of w cells in the accumulated row
   always_comb begin
      fit_found = 1'b0;
      fit_x     = '0;
      for (int x = W - 1; x >= 0; x--) begin
         if ((x + int'(w_ff) <= int'(cols)) && (((acc_ff >> x) & wmask) == '0)) begin
            fit_found = 1'b1;
            fit_x     = OW'(x);
         end
      end
      anchor_full = XW'(sbase_ff) + XW'(px_ff);
      own_sum     = rowlin_ff + (LW + 1)'(px_ff) + (LW + 1)'(dx_ff);
   end

   always_comb begin
      sts.is_query  = (mode_ff == MODE_QUERY);
      sts.q_in      = (int'(q_ff) < int'(cells));
      sts.q_done    = (qoff_ff < QW'(W));
      sts.pre_ok    = (w_ff != '0) && (h_ff != '0) && !count_ff[COUNT_W-1] &&
                      (int'(w_ff) <= int'(cols)) && (int'(h_ff) <= int'(rows));
      sts.dy_last   = (dy_ff == h_ff - 5'd1);
      sts.fit_found = fit_found;
      sts.top_last  = (int'(sy_ff) + int'(h_ff) >= int'(rows));
      sts.dx_last   = (dx_ff == w_ff - 5'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff <= CFG_W'(16);
         cfg_rows_ff <= CFG_W'(16);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_GRID_COLUMNS: cfg_cols_ff <= csr_wr_data;
            REG_GRID_ROWS:    cfg_rows_ff <= csr_wr_data;
            default:          cfg_rows_ff <= cfg_rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < NR; i++) begin
            occ_vld_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.finish) count_ff <= count_ff + 1'b1;
         if (wr_en) occ_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_lo_ff  <= occ_mem[rd_addr];
         rd_hi_ff  <= occ_mem[rd_addr_hi];
         vld_lo_ff <= occ_vld_ff[rd_addr];
         vld_hi_ff <= hi_ok && occ_vld_ff[rd_addr_hi];
      end
      if (wr_en) occ_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.q_read) own_rd_ff <= own_mem[LW'(q_ff)];
      if (cmd.own_wr) own_mem[own_sum[LW-1:0]] <= {(dy_ff == '0) && (dx_ff == '0),
                                                   count_ff[NUM_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_tdata[0];
         w_ff     <= req_tdata[5:1];
         h_ff     <= req_tdata[10:6];
         q_ff     <= req_tdata[18:11];
         qoff_ff  <= QW'(req_tdata[18:11]);
         qword_ff <= '0;
      end
      if (cmd.q_step) begin
         qoff_ff  <= qoff_ff - QW'(W);
         qword_ff <= qword_ff + 1'b1;
      end
      if (cmd.s_init) begin
         sy_ff    <= '0;
         sw_ff    <= '0;
         so_ff    <= '0;
         rw_ff    <= '0;
         ro_ff    <= '0;
         sbase_ff <= '0;
         dy_ff    <= '0;
         acc_ff   <= '0;
      end
      if (cmd.acc_row) begin
         acc_ff <= acc_ff | rowbits;
         rw_ff  <= rw_in;
         ro_ff  <= ro_in;
         dy_ff  <= dy_ff + 1'b1;
      end
      if (cmd.next_top) begin
         sy_ff    <= sy_ff + 1'b1;
         sbase_ff <= sbase_ff + (LW + 1)'(cols);
         sw_ff    <= sw_in;
         so_ff    <= so_in;
         rw_ff    <= sw_in;
         ro_ff    <= so_in;
         dy_ff    <= '0;
         acc_ff   <= '0;
      end
      if (cmd.p_init) begin
         px_ff     <= fit_x;
         rw_ff     <= sw_ff;
         ro_ff     <= so_ff;
         rowlin_ff <= sbase_ff;
         dy_ff     <= '0;
      end
      if (cmd.own_init) dx_ff <= '0;
      if (cmd.own_wr) dx_ff <= dx_ff + 1'b1;
      if (cmd.p_next_row) begin
         dy_ff     <= dy_ff + 1'b1;
         rowlin_ff <= rowlin_ff + (LW + 1)'(cols);
         rw_ff     <= rw_in;
         ro_ff     <= ro_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_empty || cmd.set_nofit) begin
         res_status_ff    <= cmd.set_empty ? ST_EMPTY : ST_NO_FIT;
         res_anchor_ff    <= '0;
         res_owner_ff     <= '0;
         res_is_anchor_ff <= 1'b0;
      end
      if (cmd.set_query) begin
         res_anchor_ff <= '0;
         if (lo_word[qoff_ff[OW-1:0]]) begin
            res_status_ff    <= ST_OCCUPIED;
            res_owner_ff     <= own_rd_ff[NUM_W-1:0];
            res_is_anchor_ff <= own_rd_ff[NUM_W];
         end else begin
            res_status_ff    <= ST_EMPTY;
            res_owner_ff     <= '0;
            res_is_anchor_ff <= 1'b0;
         end
      end
      if (cmd.finish) begin
         res_status_ff    <= ST_PLACED;
         res_anchor_ff    <= anchor_full[7:0];
         res_owner_ff     <= count_ff[NUM_W-1:0];
         res_is_anchor_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff    <= res_status_ff;
         rsp_anchor_ff    <= res_anchor_ff;
         rsp_owner_ff     <= res_owner_ff;
         rsp_is_anchor_ff <= res_is_anchor_ff;
      end
   end

   assign rsp_tdata = {5'b0, rsp_is_anchor_ff, rsp_owner_ff, rsp_anchor_ff, rsp_status_ff};

endmodule

// ----- hw/rtl/grid_rectangle_first_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// grid_rectangle_first_fit_allocator
// First-fit rectangle placement and cell lookup over a row-major grid.
// ----------------------------------------------------------------------------
// Query: steps to the memory word that holds query_cell, reads it, then hands off.
// Place: scans candidate top rows for the first fit, then writes the rectangle;
//   the scan reads one grid row (two memory words) at a time.
// One item in flight; the next is taken while the last result waits.
// Reset: geometry 16 x 16, all cells free (per-word valid bits), count zero.
module grid_rectangle_first_fit_allocator
   import grfa_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mode, rect_width, rect_height, query_cell
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, anchor_index, owner_number, cell_is_anchor
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [0:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   grfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   grfa_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ----- bench/grid_allocator_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_allocator_checker
// Watches the request, response and register ports of the allocator, keeps
// its own copy of the occupancy grid, predicts every response and compares
// each field in order. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module grid_allocator_checker
   import grfa_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [0:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wr_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    placed_total,
   output int                    occupied_hits
);

   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int ITEM_LIMIT = 256;

   // lowest field last, matching the response packing
   typedef struct packed {
      logic             is_anchor;
      logic [NUM_W-1:0] owner;
      logic [7:0]       anchor;
      logic [1:0]       status;
   } alloc_rsp_type;

   logic [CFG_W-1:0]   cols_reg;
   logic [CFG_W-1:0]   rows_reg;
   logic               occ_map [DEPTH];
   logic [NUM_W-1:0]   owner_map [DEPTH];
   logic               anchor_map [DEPTH];
   logic [COUNT_W-1:0] num_placed;
   alloc_rsp_type      rsp_queue[$];

   function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Predict one response and update the shadow grid.
   task automatic allocate_or_lookup(input logic [REQ_DATA_W-1:0] d);
      alloc_rsp_type r;
      int cols, rows, cells, w, h, q, idx;
      logic fits;
      cols  = clamp_dim(cols_reg, MAX_COLUMNS);
      rows  = clamp_dim(rows_reg, MAX_ROWS);
      cells = cols * rows;
      w = d[5:1];
      h = d[10:6];
      q = d[18:11];
      r = '{status: ST_NO_FIT, anchor: 0, owner: 0, is_anchor: 0};
      if (d[0] == MODE_QUERY) begin
         if (q < cells && occ_map[q]) begin
            r.status    = ST_OCCUPIED;
            r.owner     = owner_map[q];
            r.is_anchor = anchor_map[q];
            occupied_hits++;
         end else begin
            r.status = ST_EMPTY;
         end
      end else if (w != 0 && h != 0 && num_placed < ITEM_LIMIT) begin
         for (int s = 0; s < cells; s++) begin
            if ((s % cols) + w > cols || (s / cols) + h > rows) continue;
            fits = 1'b1;
            for (int dy = 0; dy < h; dy++)
               for (int dx = 0; dx < w; dx++) begin
                  idx = s + dy * cols + dx;
                  if (idx >= DEPTH || occ_map[idx]) fits = 1'b0;
               end
            if (!fits) continue;
            for (int dy = 0; dy < h; dy++)
               for (int dx = 0; dx < w; dx++) begin
                  idx = s + dy * cols + dx;
                  occ_map[idx]    = 1'b1;
                  owner_map[idx]  = num_placed[NUM_W-1:0];
                  anchor_map[idx] = (idx == s);
               end
            r.status = ST_PLACED;
            r.anchor = s[7:0];
            r.owner  = num_placed[NUM_W-1:0];
            num_placed++;
            placed_total++;
            break;
         end
      end
      rsp_queue = {rsp_queue, r};
   endtask

   always @(posedge clock) begin
      alloc_rsp_type want;
      alloc_rsp_type got;
      if (reset) begin
         cols_reg      <= 5'd16;
         rows_reg      <= 5'd16;
         num_placed    = '0;
         fail_count    = 0;
         placed_total  = 0;
         occupied_hits = 0;
         for (int i = 0; i < DEPTH; i++) begin
            occ_map[i]    = 1'b0;
            owner_map[i]  = '0;
            anchor_map[i] = 1'b0;
         end
         rsp_queue.delete();
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_GRID_COLUMNS) cols_reg <= csr_wr_data;
            else rows_reg <= csr_wr_data;
         end
         if (req_tvalid && req_tready) allocate_or_lookup(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[18:0];
            if (rsp_queue.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = rsp_queue.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.anchor != want.anchor)
                  report_mismatch("anchor_index", got.anchor, want.anchor);
               if (got.owner != want.owner)
                  report_mismatch("owner_number", got.owner, want.owner);
               if (got.is_anchor != want.is_anchor)
                  report_mismatch("cell_is_anchor", got.is_anchor, want.is_anchor);
            end
         end
         pending_count <= rsp_queue.size();
      end
   end

endmodule

// ----- bench/tb_grid_rectangle_first_fit_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_rectangle_first_fit_allocator
// Drives place and query items through the allocator over several grid
// geometries and flow-control mixes; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_grid_rectangle_first_fit_allocator;
   import grfa_pkg::*;

   localparam int CYCLE_LIMIT = 5000000;
   localparam int DRAIN_CYCLES = 1500;
   localparam int NUM_PHASES = 6;
   localparam int PHASE_ITEMS = 155;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [0:0]            csr_index = REG_GRID_COLUMNS;
   logic [CFG_W-1:0]      csr_wr_data = '0;

   int fail_count, pending_count, placed_total, occupied_hits;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int items_sent = 0;

   int phase_cols  [NUM_PHASES] = '{3, 0, 31, 16, 1, 7};
   int phase_rows  [NUM_PHASES] = '{4, 0, 31, 1, 16, 9};
   int phase_send  [NUM_PHASES] = '{0, 45, 0, 29, 0, 45};
   int phase_stall [NUM_PHASES] = '{0, 0, 45, 29, 0, 45};

   grid_rectangle_first_fit_allocator dut (.*);

   grid_allocator_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_wr_en, .csr_index, .csr_wr_data,
      .fail_count, .pending_count, .placed_total, .occupied_hits
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_grid_rectangle_first_fit_allocator NOT OK");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_item(input logic mode, input int w,
                                                       input int h, input int q);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[0]     = mode;
      d[5:1]   = w[4:0];
      d[10:6]  = h[4:0];
      d[18:11] = q[7:0];
      return d;
   endfunction

   // Called right after a rising edge; leaves the item accepted at a later edge.
   task automatic send_item(input logic [REQ_DATA_W-1:0] d);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input int v);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v[CFG_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(4, 1);
      if (r < 85) return $urandom_range(16);
      return $urandom_range(31);
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-grid queries, zero and oversize places, small fills
      write_reg(REG_GRID_COLUMNS, 16);
      write_reg(REG_GRID_ROWS, 16);
      send_item(pack_item(MODE_QUERY, 0, 0, 0));
      send_item(pack_item(MODE_QUERY, 31, 31, 255));
      send_item(pack_item(MODE_PLACE, 0, 5, 0));
      send_item(pack_item(MODE_PLACE, 5, 0, 0));
      send_item(pack_item(MODE_PLACE, 0, 0, 255));
      send_item(pack_item(MODE_PLACE, 31, 31, 0));
      send_item(pack_item(MODE_PLACE, 17, 1, 0));
      send_item(pack_item(MODE_PLACE, 1, 17, 0));
      send_item(pack_item(MODE_PLACE, 16, 1, 0));
      send_item(pack_item(MODE_PLACE, 1, 2, 0));
      send_item(pack_item(MODE_PLACE, 3, 3, 0));
      send_item(pack_item(MODE_PLACE, 16, 16, 0));
      send_item(pack_item(MODE_PLACE, 16, 15, 0));
      send_item(pack_item(MODE_QUERY, 0, 0, 0));
      send_item(pack_item(MODE_QUERY, 0, 0, 15));
      send_item(pack_item(MODE_QUERY, 0, 0, 16));
      send_item(pack_item(MODE_QUERY, 0, 0, 17));
      send_item(pack_item(MODE_QUERY, 0, 0, 50));
      send_item(pack_item(MODE_QUERY, 0, 0, 200));
      drain_responses();

      for (int p = 0; p < NUM_PHASES; p++) begin
         repeat (5) @(posedge clock);
         write_reg(REG_GRID_COLUMNS, phase_cols[p]);
         write_reg(REG_GRID_ROWS, phase_rows[p]);
         send_idle_pct = phase_send[p];
         stall_pct     = phase_stall[p];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off mid-phase until the block has caught up
            if (p == 1 && i == PHASE_ITEMS / 2) drain_responses();
            if ($urandom_range(99) < 55)
               send_item(pack_item(MODE_PLACE, pick_size(), pick_size(),
                                   $urandom_range(255)));
            else
               send_item(pack_item(MODE_QUERY, $urandom_range(31), $urandom_range(31),
                                   $urandom_range(255)));
         end
         drain_responses();
      end

      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d items over %0d geometries: %0d rectangles placed, %0d hits",
               items_sent, NUM_PHASES + 1, placed_total, occupied_hits);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_grid_rectangle_first_fit_allocator OK");
      end else begin
         $display("%0d mismatches, %0d items outstanding", fail_count, pending_count);
         $display("tb_grid_rectangle_first_fit_allocator NOT OK");
      end
      $finish;
   end

endmodule
